// File: hdl/esm_pkg.sv
`timescale 1ns / 1ps

package esm_pkg;

    localparam int ERR_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int CNT8_W  = 8;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 36;
    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [ERR_W-1:0]  ALL_ONES   = '1;
    localparam logic [6:0]        GL_SCALE   = 7'd100;
    localparam logic [9:0]        TP_SCALE   = 10'd1000;
    localparam logic [CNT8_W-1:0] UP_MAX     = 8'd255;

    localparam logic [ERR_W-1:0]  GL_THR_RST = 32'h0001_0000;
    localparam logic [ERR_W-1:0]  TP_THR_RST = 32'h0001_0000;
    localparam logic [ERR_W-1:0]  PQ_THR_RST = 32'h0001_0000;
    localparam logic [CNT8_W-1:0] UP_LIM_RST = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GL_THRESHOLD = 2'd0,
        CFG_TP_THRESHOLD = 2'd1,
        CFG_PQ_THRESHOLD = 2'd2,
        CFG_UP_LIMIT     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ERR_W-1:0] quot;
    } div_rsp_t;

endpackage

// File: hdl/esm_sample_if.sv
`timescale 1ns / 1ps

interface esm_sample_if;
    logic                      valid;
    logic                      ready;
    logic [esm_pkg::ERR_W-1:0] train_error;
    logic [esm_pkg::ERR_W-1:0] valid_error;

    modport source (output valid, output train_error, output valid_error, input ready);
    modport sink (input valid, input train_error, input valid_error, output ready);
endinterface

// File: hdl/esm_result_if.sv
`timescale 1ns / 1ps

interface esm_result_if;
    logic                       valid;
    logic                       ready;
    logic [esm_pkg::ERR_W-1:0]  gl_value;
    logic [esm_pkg::ERR_W-1:0]  tp_value;
    logic [esm_pkg::ERR_W-1:0]  pq_value;
    logic [esm_pkg::CNT8_W-1:0] up_count;
    logic                       gl_exceeded;
    logic                       tp_below;
    logic                       pq_exceeded;
    logic                       up_reached;
    logic                       stop_now;
    logic                       window_full;

    modport source (output valid, output gl_value, output tp_value, output pq_value,
                    output up_count, output gl_exceeded, output tp_below,
                    output pq_exceeded, output up_reached, output stop_now,
                    output window_full, input ready);
    modport sink (input valid, input gl_value, input tp_value, input pq_value,
                  input up_count, input gl_exceeded, input tp_below,
                  input pq_exceeded, input up_reached, input stop_now,
                  input window_full, output ready);
endinterface

// File: hdl/esm_cfg_if.sv
`timescale 1ns / 1ps

interface esm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [esm_pkg::CFG_IDX_W-1:0] index;
    logic [esm_pkg::ERR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/esm_div.sv
`timescale 1ns / 1ps

module esm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  esm_pkg::div_req_t req,
    output esm_pkg::div_rsp_t rsp
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } div_state_t;

    localparam int LO_W = esm_pkg::NUM_W - esm_pkg::ERR_W;

    div_state_t                  state_reg, state_next;
    logic                        done_reg, done_next;
    logic [esm_pkg::STEP_W-1:0]  cnt_reg;
    logic [esm_pkg::DEN_W:0]     rem_reg;
    logic [esm_pkg::ERR_W-1:0]   lo_reg;
    logic [esm_pkg::ERR_W-1:0]   quot_reg;
    logic [esm_pkg::DEN_W-1:0]   den_reg;
    logic [esm_pkg::DEN_W:0]     trial;
    logic                        fits;
    logic                        sat;

    assign trial = {rem_reg[esm_pkg::DEN_W-1:0], lo_reg[esm_pkg::ERR_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    // quotient does not fit in 32 bits when the upper half already reaches the divisor
    assign sat   = (esm_pkg::DEN_W'(req.num[esm_pkg::NUM_W-1 -: LO_W]) >= req.den);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    if (req.num == '0 || sat)
                        done_next = 1'b1;
                    else
                        state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (cnt_reg == '1)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
                state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && req.start)
        begin
            den_reg <= req.den;
            cnt_reg <= '0;
            rem_reg <= (esm_pkg::DEN_W + 1)'(req.num[esm_pkg::NUM_W-1 -: LO_W]);
            lo_reg  <= req.num[esm_pkg::ERR_W-1:0];
            if (req.num == '0)
                quot_reg <= '0;
            else if (sat)
                quot_reg <= esm_pkg::ALL_ONES;
            else
                quot_reg <= '0;
        end
        else if (state_reg == D_RUN)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            lo_reg   <= {lo_reg[esm_pkg::ERR_W-2:0], 1'b0};
            rem_reg  <= fits ? (trial - {1'b0, den_reg}) : trial;
            quot_reg <= {quot_reg[esm_pkg::ERR_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// File: hdl/early_stopping_monitor.sv
`timescale 1ns / 1ps
// A transaction scans the STRIP_LENGTH ring slots, then runs one division (three once the
// window is full) on one shared restoring divider, which skips its bit loop when the quotient
// is zero or saturates; after the last division, state S_OUT loads the output register.
// The input is not ready until the result is handed to the output register.
// Reset: rst_n asynchronous, active low; thresholds to defaults, validations to all ones.

module early_stopping_monitor #(
    parameter int STRIP_LENGTH = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    esm_sample_if.sink   sample,
    esm_result_if.source result,
    esm_cfg_if.sink      cfg
);

    localparam int IDX_W = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;
    localparam int CNT_W = $clog2(STRIP_LENGTH + 1);
    localparam int SUM_W = esm_pkg::ERR_W + $clog2(STRIP_LENGTH);
    localparam int PROD_W = esm_pkg::NUM_W - esm_pkg::FRAC_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRIP_LENGTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STRIP_LENGTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_GL   = 6'b000100,
        S_TP   = 6'b001000,
        S_PQ   = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [esm_pkg::ERR_W-1:0]  gl_thr_reg, tp_thr_reg, pq_thr_reg;
    logic [esm_pkg::CNT8_W-1:0] up_lim_reg;

    logic [esm_pkg::ERR_W-1:0]  best_reg, strip_reg;
    logic [esm_pkg::CNT8_W-1:0] incr_reg;
    logic [IDX_W-1:0]           slot_reg;
    logic [CNT_W-1:0]           seen_reg;

    logic [esm_pkg::ERR_W-1:0]  ring [STRIP_LENGTH];
    logic [esm_pkg::ERR_W-1:0]  tr_reg, va_reg;
    logic                       first_reg, full_reg;
    logic [IDX_W-1:0]           cur_slot_reg, j_reg;
    logic [SUM_W-1:0]           sum_reg, lmin_reg;
    logic [esm_pkg::ERR_W-1:0]  min_reg;
    logic [esm_pkg::ERR_W-1:0]  gl_reg, tp_reg, pq_reg;
    logic                       go_reg, go_next;

    logic [esm_pkg::ERR_W-1:0]  scan_val;
    logic                       accept;
    logic [esm_pkg::ERR_W-1:0]  va_best;
    logic [38:0]                gl_prod;
    logic [SUM_W-1:0]           tp_diff;
    logic [PROD_W-1:0]          tp_prod;
    logic                       out_load;

    logic                       out_valid_reg;
    logic [esm_pkg::ERR_W-1:0]  o_gl_reg, o_tp_reg, o_pq_reg;
    logic [esm_pkg::CNT8_W-1:0] o_up_reg;
    logic                       o_fgl_reg, o_ftp_reg, o_fpq_reg, o_fup_reg, o_full_reg;
    logic                       f_gl, f_tp, f_pq, f_up;

    esm_pkg::div_req_t div_req;
    esm_pkg::div_rsp_t div_rsp;

    esm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;

    assign scan_val = (first_reg || j_reg == cur_slot_reg) ? tr_reg : ring[j_reg];

    assign va_best = va_reg - best_reg;
    assign gl_prod = 39'(va_best) * 39'(esm_pkg::GL_SCALE);
    assign tp_diff = sum_reg - lmin_reg;
    assign tp_prod = PROD_W'(tp_diff) * PROD_W'(esm_pkg::TP_SCALE);

    always_comb
    begin
        div_req.start = go_reg;
        div_req.num   = {9'b0, gl_prod, esm_pkg::FRAC_W'(0)};
        div_req.den   = esm_pkg::DEN_W'(best_reg);
        case (state_reg)
            S_TP:
            begin
                div_req.num = {tp_prod, esm_pkg::FRAC_W'(0)};
                div_req.den = esm_pkg::DEN_W'(lmin_reg);
            end
            S_PQ:
            begin
                div_req.num = {esm_pkg::FRAC_W'(0), gl_reg, esm_pkg::FRAC_W'(0)};
                div_req.den = esm_pkg::DEN_W'(tp_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_SCAN;
            S_SCAN:
                if (j_reg == LAST_IDX)
                begin
                    state_next = S_GL;
                    go_next    = 1'b1;
                end
            S_GL:
                if (div_rsp.done)
                begin
                    if (full_reg)
                    begin
                        state_next = S_TP;
                        go_next    = 1'b1;
                    end
                    else
                        state_next = S_OUT;
                end
            S_TP:
                if (div_rsp.done)
                begin
                    state_next = S_PQ;
                    go_next    = 1'b1;
                end
            S_PQ:
                if (div_rsp.done)
                    state_next = S_OUT;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign f_gl = (gl_reg > gl_thr_reg);
    assign f_tp = full_reg && (tp_reg < tp_thr_reg);
    assign f_pq = full_reg && (pq_reg > pq_thr_reg);
    assign f_up = (incr_reg >= up_lim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            gl_thr_reg    <= esm_pkg::GL_THR_RST;
            tp_thr_reg    <= esm_pkg::TP_THR_RST;
            pq_thr_reg    <= esm_pkg::PQ_THR_RST;
            up_lim_reg    <= esm_pkg::UP_LIM_RST;
            best_reg      <= esm_pkg::ALL_ONES;
            strip_reg     <= esm_pkg::ALL_ONES;
            incr_reg      <= '0;
            slot_reg      <= '0;
            seen_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid && cfg.ready)
            begin
                case (esm_pkg::cfg_index_t'(cfg.index))
                    esm_pkg::CFG_GL_THRESHOLD: gl_thr_reg <= cfg.data;
                    esm_pkg::CFG_TP_THRESHOLD: tp_thr_reg <= cfg.data;
                    esm_pkg::CFG_PQ_THRESHOLD: pq_thr_reg <= cfg.data;
                    esm_pkg::CFG_UP_LIMIT:     up_lim_reg <= cfg.data[esm_pkg::CNT8_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
            begin
                if (sample.valid_error < best_reg)
                    best_reg <= sample.valid_error;
                // strip start: count successive increases
                if (slot_reg == '0)
                begin
                    if (strip_reg < sample.valid_error)
                    begin
                        if (incr_reg != esm_pkg::UP_MAX)
                            incr_reg <= incr_reg + 1'b1;
                    end
                    else
                        incr_reg <= '0;
                    strip_reg <= sample.valid_error;
                end
                slot_reg <= (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
                if (seen_reg != FULL_CNT)
                    seen_reg <= seen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tr_reg       <= sample.train_error;
            va_reg       <= sample.valid_error;
            first_reg    <= (seen_reg == '0);
            full_reg     <= (seen_reg >= FULL_CNT - 1'b1);
            cur_slot_reg <= slot_reg;
            j_reg        <= '0;
        end

        if (state_reg == S_SCAN)
        begin
            ring[j_reg] <= scan_val;
            sum_reg     <= ((j_reg == '0) ? '0 : sum_reg) + SUM_W'(scan_val);
            if (j_reg == '0 || scan_val < min_reg)
                min_reg <= scan_val;
            if (j_reg != LAST_IDX)
                j_reg <= j_reg + 1'b1;
        end

        if (state_reg == S_GL)
        begin
            lmin_reg <= SUM_W'(min_reg) * SUM_W'(STRIP_LENGTH);
            tp_reg   <= esm_pkg::ALL_ONES;
            pq_reg   <= '0;
            if (div_rsp.done)
                gl_reg <= div_rsp.quot;
        end
        if (state_reg == S_TP && div_rsp.done)
            tp_reg <= div_rsp.quot;
        if (state_reg == S_PQ && div_rsp.done)
            pq_reg <= div_rsp.quot;

        if (out_load)
        begin
            o_gl_reg   <= gl_reg;
            o_tp_reg   <= tp_reg;
            o_pq_reg   <= pq_reg;
            o_up_reg   <= incr_reg;
            o_fgl_reg  <= f_gl;
            o_ftp_reg  <= f_tp;
            o_fpq_reg  <= f_pq;
            o_fup_reg  <= f_up;
            o_full_reg <= full_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.gl_value    = o_gl_reg;
    assign result.tp_value    = o_tp_reg;
    assign result.pq_value    = o_pq_reg;
    assign result.up_count    = o_up_reg;
    assign result.gl_exceeded = o_fgl_reg;
    assign result.tp_below    = o_ftp_reg;
    assign result.pq_exceeded = o_fpq_reg;
    assign result.up_reached  = o_fup_reg;
    assign result.stop_now    = o_fgl_reg || o_ftp_reg || o_fpq_reg || o_fup_reg;
    assign result.window_full = o_full_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample.ready)
        else $error("input ready right after a transaction");

    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_GL || state_reg == S_TP || state_reg == S_PQ))
        else $error("divider finished outside a division step");

    a_not_full_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.window_full) |->
            (result.tp_value == esm_pkg::ALL_ONES && result.pq_value == '0))
        else $error("progress or quotient set before window full");

endmodule
